/* rtl/look_at_view_matrix_core_macros.svh */
// Assertion macros used by the look-at view matrix core.
`ifndef LOOK_AT_VIEW_MATRIX_CORE_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LVM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lvm_pkg.sv */
// Types, constants and rounding helpers for the look-at view matrix core.
`timescale 1ns / 1ps
package lvm_pkg;

	localparam int ROT_FRAC = 30;

	typedef logic [2:0][31:0] vec3_t;

	typedef enum logic [1:0] {
		ROW_SIDE = 2'd0,
		ROW_UP   = 2'd1,
		ROW_FWD  = 2'd2
	} row_t;

	localparam logic signed [31:0] ROT_ONE = 32'sd1073741824;

	// Round half away from zero by ROT_FRAC bits.
	function automatic logic signed [33:0] round30(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = v + (v[63] ? 64'sd536870911 : 64'sd536870912);
		return t[63:ROT_FRAC];
	endfunction

	function automatic logic [31:0] sat32(input logic signed [33:0] r);
		logic [31:0] res;
		if (r > 34'sd2147483647) begin
			res = 32'h7fff_ffff;
		end else if (r < -34'sd2147483648) begin
			res = 32'h8000_0000;
		end else begin
			res = r[31:0];
		end
		return res;
	endfunction

	function automatic logic [31:0] clamp_rot(input logic signed [33:0] r);
		logic [31:0] res;
		if (r > 34'sd1073741824) begin
			res = ROT_ONE;
		end else if (r < -34'sd1073741824) begin
			res = -ROT_ONE;
		end else begin
			res = r[31:0];
		end
		return res;
	endfunction

endpackage

/* rtl/look_at_view_matrix_core.sv */
// Look-at view matrix core: eye, target and up in, three matrix rows out.
`timescale 1ns / 1ps
`include "look_at_view_matrix_core_macros.svh"
// The core takes one camera description per beat (eye, target and up, signed Q16.16) and
// returns the top three rows of the view matrix as three beats: side, true up and negated
// forward, each with Q2.30 rotation entries and a saturated Q16.16 translation. The pipeline
// can take an item in every cycle while in_stall is low, but the result channel carries
// three beats per item, so the input stalls while the output buffer still holds rows of an
// item and the last stage is full. The datapath runs through two chained normalisers, each
// of which holds a two-bit-per-stage square root and a two-bit-per-stage divider.
module look_at_view_matrix_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] eye_x,
	input  logic signed [31:0] eye_y,
	input  logic signed [31:0] eye_z,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic signed [31:0] up_x,
	input  logic signed [31:0] up_y,
	input  logic signed [31:0] up_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         row_index,
	output logic signed [31:0] col_x,
	output logic signed [31:0] col_y,
	output logic signed [31:0] col_z,
	output logic signed [31:0] translation,
	output logic               degenerate,
	output logic               last_row
);
	import lvm_pkg::*;

	logic adv, out_fire;

	logic              s1_valid;
	vec3_t             eye_s1, up_s1;
	logic [2:0][32:0]  d_s1;

	logic              na_valid, f_nz;
	vec3_t             f_n, upn_n, eye_n;

	logic              s2_valid, ok_s2;
	logic signed [63:0] xp_s2 [6];
	vec3_t             f_s2, eye_s2;

	logic              s3_valid, ok_s3;
	logic [2:0][62:0]  c_s3;
	vec3_t             f_s3, eye_s3;

	logic              nc_valid, s_nz, ok_c;
	vec3_t             s_n, f_c, eye_c;
	logic [192:0]      side_c;

	logic              s4_valid, ok_s4;
	logic signed [63:0] up_s4 [6];
	logic signed [63:0] ds_s4 [3];
	logic signed [63:0] df_s4 [3];
	vec3_t             s_s4, f_s4, eye_s4;

	logic              s5_valid, ok_s5;
	logic signed [63:0] c2_s5 [3];
	logic signed [63:0] dsn_s5, dfs_s5;
	vec3_t             s_s5, f_s5, eye_s5;

	logic              s6_valid, ok_s6;
	vec3_t             s_s6, u_s6, f_s6, eye_s6;
	logic [31:0]       ts_s6, tf_s6;

	logic              s7_valid, ok_s7;
	logic signed [63:0] pu_s7 [3];
	vec3_t             s_s7, u_s7, f_s7;
	logic [31:0]       ts_s7, tf_s7;

	logic              s8_valid, ok_s8;
	logic signed [63:0] dun_s8;
	vec3_t             s_s8, u_s8, f_s8;
	logic [31:0]       ts_s8, tf_s8;

	logic              s9_valid, ok_s9;
	vec3_t             s_s9, u_s9, nf_s9;
	logic [31:0]       ts_s9, tu_s9, tf_s9;

	logic              ob_valid_q, ob_deg_q;
	row_t              row_q;
	vec3_t             ob_col_q [3];
	vec3_t             ob_tr_q;
	vec3_t             sel_col;
	logic [31:0]       sel_tr;
	logic              rot_ok, deg_ok;

	assign out_fire = out_valid && !out_stall;
	assign adv      = !s9_valid || !ob_valid_q || (out_fire && row_q == ROW_FWD);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
			s3_valid <= 1'b0;
			s4_valid <= 1'b0;
			s5_valid <= 1'b0;
			s6_valid <= 1'b0;
			s7_valid <= 1'b0;
			s8_valid <= 1'b0;
			s9_valid <= 1'b0;
		end else if (adv) begin
			s1_valid <= in_valid;
			s2_valid <= na_valid;
			s3_valid <= s2_valid;
			s4_valid <= nc_valid;
			s5_valid <= s4_valid;
			s6_valid <= s5_valid;
			s7_valid <= s6_valid;
			s8_valid <= s7_valid;
			s9_valid <= s8_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			eye_s1 <= {eye_z, eye_y, eye_x};
			up_s1  <= {up_z, up_y, up_x};
			d_s1[0] <= 33'(target_x) - 33'(eye_x);
			d_s1[1] <= 33'(target_y) - 33'(eye_y);
			d_s1[2] <= 33'(target_z) - 33'(eye_z);
		end
	end

	lvm_norm #(.W(33), .SW(96)) u_norm_fwd (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (s1_valid),
		.v         (d_s1),
		.side      (eye_s1),
		.out_valid (na_valid),
		.o         (f_n),
		.nz        (f_nz),
		.side_o    (eye_n)
	);

	lvm_norm #(.W(32), .SW(1)) u_norm_up (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (s1_valid),
		.v         (up_s1),
		.side      (1'b0),
		.out_valid (),
		.o         (upn_n),
		.nz        (),
		.side_o    ()
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			xp_s2[0] <= $signed(f_n[1]) * $signed(upn_n[2]);
			xp_s2[1] <= $signed(f_n[2]) * $signed(upn_n[1]);
			xp_s2[2] <= $signed(f_n[2]) * $signed(upn_n[0]);
			xp_s2[3] <= $signed(f_n[0]) * $signed(upn_n[2]);
			xp_s2[4] <= $signed(f_n[0]) * $signed(upn_n[1]);
			xp_s2[5] <= $signed(f_n[1]) * $signed(upn_n[0]);
			f_s2     <= f_n;
			eye_s2   <= eye_n;
			ok_s2    <= f_nz;

			for (int i = 0; i < 3; i++) begin
				c_s3[i] <= 63'(xp_s2[2*i] - xp_s2[2*i+1]);
			end
			f_s3   <= f_s2;
			eye_s3 <= eye_s2;
			ok_s3  <= ok_s2;
		end
	end

	lvm_norm #(.W(63), .SW(193)) u_norm_side (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (s3_valid),
		.v         (c_s3),
		.side      ({ok_s3, f_s3, eye_s3}),
		.out_valid (nc_valid),
		.o         (s_n),
		.nz        (s_nz),
		.side_o    (side_c)
	);

	assign {ok_c, f_c, eye_c} = side_c;

	always_ff @(posedge clk) begin
		if (adv) begin
			up_s4[0] <= $signed(s_n[1]) * $signed(f_c[2]);
			up_s4[1] <= $signed(s_n[2]) * $signed(f_c[1]);
			up_s4[2] <= $signed(s_n[2]) * $signed(f_c[0]);
			up_s4[3] <= $signed(s_n[0]) * $signed(f_c[2]);
			up_s4[4] <= $signed(s_n[0]) * $signed(f_c[1]);
			up_s4[5] <= $signed(s_n[1]) * $signed(f_c[0]);
			for (int i = 0; i < 3; i++) begin
				ds_s4[i] <= $signed(s_n[i]) * $signed(eye_c[i]);
				df_s4[i] <= $signed(f_c[i]) * $signed(eye_c[i]);
			end
			s_s4   <= s_n;
			f_s4   <= f_c;
			eye_s4 <= eye_c;
			ok_s4  <= ok_c && s_nz;

			for (int i = 0; i < 3; i++) begin
				c2_s5[i] <= up_s4[2*i] - up_s4[2*i+1];
			end
			dsn_s5 <= 64'sd0 - ds_s4[0] - ds_s4[1] - ds_s4[2];
			dfs_s5 <= df_s4[0] + df_s4[1] + df_s4[2];
			s_s5   <= s_s4;
			f_s5   <= f_s4;
			eye_s5 <= eye_s4;
			ok_s5  <= ok_s4;

			for (int i = 0; i < 3; i++) begin
				u_s6[i] <= clamp_rot(round30(c2_s5[i]));
			end
			ts_s6  <= sat32(round30(dsn_s5));
			tf_s6  <= sat32(round30(dfs_s5));
			s_s6   <= s_s5;
			f_s6   <= f_s5;
			eye_s6 <= eye_s5;
			ok_s6  <= ok_s5;

			for (int i = 0; i < 3; i++) begin
				pu_s7[i] <= $signed(u_s6[i]) * $signed(eye_s6[i]);
			end
			s_s7  <= s_s6;
			u_s7  <= u_s6;
			f_s7  <= f_s6;
			ts_s7 <= ts_s6;
			tf_s7 <= tf_s6;
			ok_s7 <= ok_s6;

			dun_s8 <= 64'sd0 - pu_s7[0] - pu_s7[1] - pu_s7[2];
			s_s8   <= s_s7;
			u_s8   <= u_s7;
			f_s8   <= f_s7;
			ts_s8  <= ts_s7;
			tf_s8  <= tf_s7;
			ok_s8  <= ok_s7;

			tu_s9 <= sat32(round30(dun_s8));
			for (int i = 0; i < 3; i++) begin
				nf_s9[i] <= -f_s8[i];
			end
			s_s9  <= s_s8;
			u_s9  <= u_s8;
			ts_s9 <= ts_s8;
			tf_s9 <= tf_s8;
			ok_s9 <= ok_s8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_valid_q <= 1'b0;
			row_q      <= ROW_SIDE;
		end else begin
			if (out_fire) begin
				case (row_q)
					ROW_SIDE: row_q <= ROW_UP;
					ROW_UP:   row_q <= ROW_FWD;
					default: begin
						row_q      <= ROW_SIDE;
						ob_valid_q <= 1'b0;
					end
				endcase
			end
			if (adv && s9_valid) begin
				ob_valid_q <= 1'b1;
				row_q      <= ROW_SIDE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s9_valid) begin
			ob_deg_q    <= !ok_s9;
			ob_col_q[0] <= ok_s9 ? s_s9 : '0;
			ob_col_q[1] <= ok_s9 ? u_s9 : '0;
			ob_col_q[2] <= ok_s9 ? nf_s9 : '0;
			ob_tr_q[0]  <= ok_s9 ? ts_s9 : '0;
			ob_tr_q[1]  <= ok_s9 ? tu_s9 : '0;
			ob_tr_q[2]  <= ok_s9 ? tf_s9 : '0;
		end
	end

	always_comb begin
		case (row_q)
			ROW_SIDE: begin
				sel_col = ob_col_q[0];
				sel_tr  = ob_tr_q[0];
			end
			ROW_UP: begin
				sel_col = ob_col_q[1];
				sel_tr  = ob_tr_q[1];
			end
			default: begin
				sel_col = ob_col_q[2];
				sel_tr  = ob_tr_q[2];
			end
		endcase
	end

	assign out_valid   = ob_valid_q;
	assign row_index   = row_q;
	assign col_x       = sel_col[0];
	assign col_y       = sel_col[1];
	assign col_z       = sel_col[2];
	assign translation = sel_tr;
	assign degenerate  = ob_deg_q;
	assign last_row    = (row_q == ROW_FWD);

	assign rot_ok = col_x <= ROT_ONE && col_x >= -ROT_ONE && col_y <= ROT_ONE &&
		col_y >= -ROT_ONE && col_z <= ROT_ONE && col_z >= -ROT_ONE;
	assign deg_ok = col_x == '0 && col_y == '0 && col_z == '0 && translation == '0;

	`LVM_ASSERT_IMPL(a_deg_zero, clk, arst_n, out_valid && degenerate, deg_ok, "degenerate row is not zero")
	`LVM_ASSERT_IMPL(a_rot_range, clk, arst_n, out_valid, rot_ok, "rotation entry beyond unit range")
	`LVM_ASSERT_IMPL(a_row_first, clk, arst_n, $rose(out_valid), row_q == ROW_SIDE, "item opens on a later row")
	`LVM_ASSERT_NEXT(a_row_cont, clk, arst_n, out_fire && !last_row, out_valid, "row lost within an item")
	`LVM_ASSERT_NEXT(a_tail_hold, clk, arst_n, s9_valid && !adv, s9_valid, "stalled item dropped")

endmodule

/* rtl/lvm_norm.sv */
// Pipelined three-component vector normaliser to signed Q2.30.
`timescale 1ns / 1ps
module lvm_norm #(
	parameter int W  = 33,
	parameter int SW = 96
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [2:0][W-1:0]   v,
	input  logic [SW-1:0]       side,
	output logic                out_valid,
	output lvm_pkg::vec3_t      o,
	output logic                nz,
	output logic [SW-1:0]       side_o
);
	import lvm_pkg::*;

	localparam int PW      = $clog2(W);
	localparam int RT_ST   = 16;
	localparam int DV_ST   = 16;
	localparam int DV_BITS = 31;

	typedef struct packed {
		logic [2:0]    neg;
		logic          nz;
		logic [SW-1:0] side;
	} car_t;

	logic            val_s1, val_s2, val_s3, val_s4, val_s5, val_s6, val_s7, val_q;
	logic [2:0][W-1:0] m_s1, m_s2, m_s3;
	logic [2:0]      neg_s1, neg_s2, neg_s3;
	logic [SW-1:0]   side_s1, side_s2, side_s3;
	logic [W-1:0]    mx_s2, mx_c;
	logic [PW-1:0]   p_s3, p_c;
	logic            nz_s3;
	logic [2:0][30:0] mn_s4, mn_s5, mn_s6, mn_c;
	car_t            car_s4, car_s5, car_s6, car_s7;
	logic [2:0][61:0] sq_s5;
	logic [63:0]     sum_s6;
	logic [2:0][61:0] n_s7;
	logic [31:0]     len_s7;

	logic [35:0]      rt_rem  [RT_ST];
	logic [31:0]      rt_root [RT_ST];
	logic [63:0]      rt_n    [RT_ST];
	logic [2:0][30:0] rt_m    [RT_ST];
	car_t             rt_car  [RT_ST];
	logic             rt_val  [RT_ST];

	logic [2:0][32:0] dv_rem [DV_ST];
	logic [2:0][30:0] dv_q   [DV_ST];
	logic [2:0][61:0] dv_n   [DV_ST];
	logic [31:0]      dv_len [DV_ST];
	car_t             dv_car [DV_ST];
	logic             dv_val [DV_ST];

	vec3_t o_c;

	always_comb begin
		mx_c = m_s1[0];
		if (m_s1[1] > mx_c) mx_c = m_s1[1];
		if (m_s1[2] > mx_c) mx_c = m_s1[2];
	end

	always_comb begin
		p_c = '0;
		for (int i = 0; i < W; i++) begin
			if (mx_s2[i]) p_c = PW'(i);
		end
	end

	always_comb begin
		logic [W-1:0] t;
		for (int i = 0; i < 3; i++) begin
			if (p_s3 > PW'(30)) begin
				t = m_s3[i] >> (p_s3 - PW'(30));
			end else begin
				t = m_s3[i] << (PW'(30) - p_s3);
			end
			mn_c[i] = t[30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
			val_s2 <= 1'b0;
			val_s3 <= 1'b0;
			val_s4 <= 1'b0;
			val_s5 <= 1'b0;
			val_s6 <= 1'b0;
			val_s7 <= 1'b0;
			val_q  <= 1'b0;
		end else if (en) begin
			val_s1 <= in_valid;
			val_s2 <= val_s1;
			val_s3 <= val_s2;
			val_s4 <= val_s3;
			val_s5 <= val_s4;
			val_s6 <= val_s5;
			val_s7 <= rt_val[RT_ST-1];
			val_q  <= dv_val[DV_ST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				m_s1[i]   <= v[i][W-1] ? (~v[i] + W'(1)) : v[i];
				neg_s1[i] <= v[i][W-1];
				sq_s5[i]  <= mn_s4[i] * mn_s4[i];
				n_s7[i]   <= 62'({rt_m[RT_ST-1][i], 30'b0}) +
					62'(rt_root[RT_ST-1][31:1]);
			end
			side_s1 <= side;
			mx_s2   <= mx_c;
			m_s2    <= m_s1;
			neg_s2  <= neg_s1;
			side_s2 <= side_s1;
			p_s3    <= p_c;
			nz_s3   <= (mx_s2 != '0);
			m_s3    <= m_s2;
			neg_s3  <= neg_s2;
			side_s3 <= side_s2;
			mn_s4   <= mn_c;
			car_s4  <= '{neg: neg_s3, nz: nz_s3, side: side_s3};
			mn_s5   <= mn_s4;
			car_s5  <= car_s4;
			sum_s6  <= 64'(sq_s5[0]) + 64'(sq_s5[1]) + 64'(sq_s5[2]);
			mn_s6   <= mn_s5;
			car_s6  <= car_s5;
			len_s7  <= rt_root[RT_ST-1];
			car_s7  <= rt_car[RT_ST-1];
			o       <= o_c;
			nz      <= dv_car[DV_ST-1].nz;
			side_o  <= dv_car[DV_ST-1].side;
		end
	end

	for (genvar g = 0; g < RT_ST; g++) begin : g_rt
		logic [35:0]      rem_i, rem_x;
		logic [31:0]      root_i, root_x;
		logic [63:0]      n_i;
		logic [2:0][30:0] m_i;
		car_t             car_i;
		logic             val_i;

		if (g == 0) begin : g_head
			assign rem_i  = '0;
			assign root_i = '0;
			assign n_i    = sum_s6;
			assign m_i    = mn_s6;
			assign car_i  = car_s6;
			assign val_i  = val_s6;
		end else begin : g_body
			assign rem_i  = rt_rem[g-1];
			assign root_i = rt_root[g-1];
			assign n_i    = rt_n[g-1];
			assign m_i    = rt_m[g-1];
			assign car_i  = rt_car[g-1];
			assign val_i  = rt_val[g-1];
		end

		always_comb begin
			rem_x  = rem_i;
			root_x = root_i;
			for (int j = 0; j < 2; j++) begin
				rem_x = {rem_x[33:0], n_i[63-2*(2*g+j) -: 2]};
				if (rem_x >= 36'({root_x, 2'b01})) begin
					rem_x  = rem_x - 36'({root_x, 2'b01});
					root_x = {root_x[30:0], 1'b1};
				end else begin
					root_x = {root_x[30:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_val[g] <= 1'b0;
			end else if (en) begin
				rt_val[g] <= val_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_rem[g]  <= rem_x;
				rt_root[g] <= root_x;
				rt_n[g]    <= n_i;
				rt_m[g]    <= m_i;
				rt_car[g]  <= car_i;
			end
		end
	end

	for (genvar g = 0; g < DV_ST; g++) begin : g_dv
		logic [2:0][32:0] rem_i, rem_x;
		logic [2:0][30:0] q_i, q_x;
		logic [2:0][61:0] n_i;
		logic [31:0]      len_i;
		car_t             car_i;
		logic             val_i;

		if (g == 0) begin : g_head
			for (genvar i = 0; i < 3; i++) begin : g_init
				assign rem_i[i] = {2'b00, n_s7[i][61:31]};
			end
			assign q_i   = '0;
			assign n_i   = n_s7;
			assign len_i = len_s7;
			assign car_i = car_s7;
			assign val_i = val_s7;
		end else begin : g_body
			assign rem_i = dv_rem[g-1];
			assign q_i   = dv_q[g-1];
			assign n_i   = dv_n[g-1];
			assign len_i = dv_len[g-1];
			assign car_i = dv_car[g-1];
			assign val_i = dv_val[g-1];
		end

		always_comb begin
			rem_x = rem_i;
			q_x   = q_i;
			for (int j = 0; j < 2; j++) begin
				if (2*g + j < DV_BITS) begin
					for (int i = 0; i < 3; i++) begin
						rem_x[i] = {rem_x[i][31:0], n_i[i][DV_BITS-1-(2*g+j)]};
						if (rem_x[i] >= {1'b0, len_i}) begin
							rem_x[i] = rem_x[i] - {1'b0, len_i};
							q_x[i]   = {q_x[i][29:0], 1'b1};
						end else begin
							q_x[i]   = {q_x[i][29:0], 1'b0};
						end
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_val[g] <= 1'b0;
			end else if (en) begin
				dv_val[g] <= val_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem[g] <= rem_x;
				dv_q[g]   <= q_x;
				dv_n[g]   <= n_i;
				dv_len[g] <= len_i;
				dv_car[g] <= car_i;
			end
		end
	end

	always_comb begin
		logic [31:0] qc;
		for (int i = 0; i < 3; i++) begin
			qc = {1'b0, dv_q[DV_ST-1][i]};
			if (qc > ROT_ONE) qc = ROT_ONE;
			if (!dv_car[DV_ST-1].nz) begin
				o_c[i] = '0;
			end else if (dv_car[DV_ST-1].neg[i]) begin
				o_c[i] = -qc;
			end else begin
				o_c[i] = qc;
			end
		end
	end

	assign out_valid = val_q;

endmodule
